// ----- src/hdsd_pkg.sv -----
// Shared types, constants and helpers of the Huffman delta sample decoder.
`default_nettype none
package hdsd_pkg;

    localparam int IDX_W    = 14;
    localparam int VAL_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int AXIS_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int HDR_W    = 12;
    localparam int HDR_CNT_W = 4;
    localparam int QDEPTH   = 2;
    localparam int QAW      = 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DIFFERENCE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHOLE_SYMBOLS   = 2'd1;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [HDR_CNT_W-1:0] HDR_LAST_CNT = 4'd11;

    localparam logic [VAL_W-1:0] SUB_4096  = 16'hF000;
    localparam logic [VAL_W-1:0] SUB_2048  = 16'hF800;
    localparam logic [VAL_W-1:0] SIGN_FILL = 16'hF000;

    typedef struct packed {
        logic              leaf;
        logic [IDX_W-1:0]  left;
        logic [IDX_W-1:0]  right;
        logic [VAL_W-1:0]  value;
    } node_t;

    typedef struct packed {
        logic              is_data;
        logic [IDX_W-1:0]  idx;
        node_t             node;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic difference_mode;
        logic whole_symbols;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    function automatic logic [VAL_W-1:0] sext12(input logic [HDR_W-1:0] v);
        logic [VAL_W-1:0] r;
        r = {4'd0, v};
        if (v[HDR_W-1])
        begin
            r = r | SIGN_FILL;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/hdsd_if.sv -----
// Channel interfaces: input items, result samples and configuration writes.
`default_nettype none
interface hdsd_in_if;
    import hdsd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [IDX_W-1:0]         node_index;
    logic                     node_is_leaf;
    logic [IDX_W-1:0]         node_left;
    logic [IDX_W-1:0]         node_right;
    logic signed [VAL_W-1:0]  node_value;
    logic [BYTE_W-1:0]        data_byte;

    modport source (output valid, operation, node_index, node_is_leaf, node_left,
                    node_right, node_value, data_byte, input ready);
    modport sink   (input valid, operation, node_index, node_is_leaf, node_left,
                    node_right, node_value, data_byte, output ready);
endinterface

interface hdsd_out_if;
    import hdsd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  sample;
    logic [AXIS_W-1:0]        axis;
    logic                     last;

    modport source (output valid, sample, axis, last, input ready);
    modport sink   (input valid, sample, axis, last, output ready);
endinterface

interface hdsd_cfg_if;
    import hdsd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic                  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/huffman_delta_sample_decoder_top.sv -----
// Top level of the Huffman delta sample decoder.
//
//   channel  | dir | payload                                        | transfer
//   item     | in  | operation, node_*, data_byte                   | valid & ready
//   result   | out | sample, axis, last                             | valid & ready
//   cfg      | in  | index, data                                    | valid & ready
//
// A load item is written to the tree table on dispatch; a data byte is walked with
// one registered tree-table read per coded bit, chained bit after bit, plus
// dispatch and a final flush state that tags the byte's last sample. Header bits
// need no table read. A two-entry queue lets the item side keep going while
// results stall; a full result register holds the back end. Reset is
// asynchronous; the tree table is not cleared and must be loaded before use.
`default_nettype none
module huffman_delta_sample_decoder_top #(
    parameter int TREE_NODES = 16384
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hdsd_in_if.sink      item,
    hdsd_out_if.source   result,
    hdsd_cfg_if.sink     cfg
);
    import hdsd_pkg::*;

    cmd_t  q_wdata;
    cmd_t  q_rdata;
    cfg_t  mode;
    logic  q_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    hdsd_front #(
        .TREE_NODES (TREE_NODES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_wdata),
        .mode   (mode)
    );

    hdsd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    hdsd_back #(
        .TREE_NODES (TREE_NODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .cmd_valid (q_valid),
        .cmd       (q_rdata),
        .cmd_pop   (q_pop),
        .result    (result)
    );

endmodule
`default_nettype wire

// ----- src/hdsd_front.sv -----
// Front end: accepts items, drops out-of-range loads, holds the mode registers.
`default_nettype none
module hdsd_front #(
    parameter int TREE_NODES = 16384
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    hdsd_in_if.sink             item,
    hdsd_cfg_if.sink            cfg,
    input  wire logic           q_full,
    output logic                q_push,
    output hdsd_pkg::cmd_t      q_cmd,
    output hdsd_pkg::cfg_t      mode
);
    import hdsd_pkg::*;

    logic diff_reg;
    logic diff_next;
    logic whole_reg;
    logic whole_next;
    logic in_range;

    assign cfg.ready  = 1'b1;
    assign item.ready = !q_full;

    assign in_range = (32'(item.node_index) < TREE_NODES);

    // Loads beyond the table never reach the back end.
    assign q_push = item.valid && item.ready && ((item.operation == OP_DATA) || in_range);

    always_comb
    begin
        q_cmd.is_data    = (item.operation == OP_DATA);
        q_cmd.idx        = item.node_index;
        q_cmd.node.leaf  = item.node_is_leaf;
        q_cmd.node.left  = item.node_left;
        q_cmd.node.right = item.node_right;
        q_cmd.node.value = item.node_value;
        q_cmd.data       = item.data_byte;
    end

    always_comb
    begin
        diff_next  = diff_reg;
        whole_next = whole_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_DIFFERENCE_MODE: diff_next  = cfg.data;
                REG_WHOLE_SYMBOLS:   whole_next = cfg.data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg  <= 1'b1;
            whole_reg <= 1'b0;
        end
        else
        begin
            diff_reg  <= diff_next;
            whole_reg <= whole_next;
        end
    end

    assign mode.difference_mode = diff_reg;
    assign mode.whole_symbols   = whole_reg;

endmodule
`default_nettype wire

// ----- src/hdsd_fifo.sv -----
// Two-entry command queue between the front and back ends.
`default_nettype none
module hdsd_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire hdsd_pkg::cmd_t   wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output hdsd_pkg::cmd_t        rdata
);
    import hdsd_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg;
    logic [QAW-1:0]    wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg;
    logic [QAW-1:0]    rd_ptr_next;
    logic [QAW:0]      count_reg;
    logic [QAW:0]      count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ----- src/hdsd_back.sv -----
// Back end: tree table, bit-serial tree walk, header capture and sample rebuild.
`default_nettype none
module hdsd_back #(
    parameter int TREE_NODES = 16384
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hdsd_pkg::cfg_t   mode,
    input  wire logic             cmd_valid,
    input  wire hdsd_pkg::cmd_t   cmd,
    output logic                  cmd_pop,
    hdsd_out_if.source            result
);
    import hdsd_pkg::*;

    localparam int DEPTH = (TREE_NODES < (1 << IDX_W)) ? TREE_NODES : (1 << IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    node_t               tree_mem [DEPTH];
    node_t               rd_data_reg;
    logic                rd_ok_reg;
    logic [IDX_W-1:0]    issue_idx_reg;

    state_t              state_reg;
    state_t              state_next;
    logic [2:0]          bit_reg;
    logic [2:0]          bit_next;
    logic [BYTE_W-1:0]   byte_reg;
    logic [BYTE_W-1:0]   byte_next;
    logic                pend_reg;
    logic                pend_next;
    logic [IDX_W-1:0]    cur_idx_reg;
    logic [IDX_W-1:0]    cur_idx_next;
    logic [IDX_W-1:0]    cur_l_reg;
    logic [IDX_W-1:0]    cur_l_next;
    logic [IDX_W-1:0]    cur_r_reg;
    logic [IDX_W-1:0]    cur_r_next;
    logic [IDX_W-1:0]    root_l_reg;
    logic [IDX_W-1:0]    root_l_next;
    logic [IDX_W-1:0]    root_r_reg;
    logic [IDX_W-1:0]    root_r_next;
    logic [HDR_W-1:0]    hdr_bits_reg;
    logic [HDR_W-1:0]    hdr_bits_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg;
    logic [HDR_CNT_W-1:0] hdr_cnt_next;
    logic                hdr_done_reg;
    logic                hdr_done_next;
    logic [AXIS_W-1:0]   axis_reg;
    logic [AXIS_W-1:0]   axis_next;
    logic                lowp_valid_reg;
    logic                lowp_valid_next;
    logic [BYTE_W-1:0]   lowp_byte_reg;
    logic [BYTE_W-1:0]   lowp_byte_next;
    logic [VAL_W-1:0]    prev_reg [3];
    logic [VAL_W-1:0]    prev_next [3];
    logic                stage_valid_reg;
    logic                stage_valid_next;
    logic [VAL_W-1:0]    stage_sample_reg;
    logic [VAL_W-1:0]    stage_sample_next;
    logic [AXIS_W-1:0]   stage_axis_reg;
    logic [AXIS_W-1:0]   stage_axis_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VAL_W-1:0]    out_sample_reg;
    logic [VAL_W-1:0]    out_sample_next;
    logic [AXIS_W-1:0]   out_axis_reg;
    logic [AXIS_W-1:0]   out_axis_next;
    logic                out_last_reg;
    logic                out_last_next;

    logic                tree_mode;
    logic                bit_val;
    logic [2:0]          bit_dn;
    node_t               child_node;
    logic [IDX_W-1:0]    nxt_l;
    logic [IDX_W-1:0]    nxt_r;
    logic [VAL_W-1:0]    prev_sel;
    logic [HDR_W-1:0]    hdr_shift;
    logic                hdr_last;
    logic                sym_take;
    logic [VAL_W-1:0]    pair_val;
    logic [HDR_W-1:0]    sum12;
    logic                new_sample;
    logic [VAL_W-1:0]    new_value;
    logic                out_free;
    logic                stall;
    logic                advance;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_idx;
    logic                wr_en;
    logic                push;
    logic                push_last;

    // The header is read only while difference mode is on and not yet complete.
    assign tree_mode  = !(mode.difference_mode && !hdr_done_reg);
    assign bit_val    = byte_reg[bit_reg];
    assign bit_dn     = bit_reg - 3'd1;
    assign child_node = rd_ok_reg ? rd_data_reg : '0;
    assign nxt_l      = child_node.leaf ? root_l_reg : child_node.left;
    assign nxt_r      = child_node.leaf ? root_r_reg : child_node.right;
    assign hdr_shift  = {hdr_bits_reg[HDR_W-2:0], bit_val};
    assign hdr_last   = (hdr_cnt_reg == HDR_LAST_CNT);
    assign pair_val   = {child_node.value[BYTE_W-1:0], lowp_byte_reg};
    assign sum12      = prev_sel[HDR_W-1:0] + child_node.value[HDR_W-1:0];
    assign out_free   = !out_valid_reg || result.ready;

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    prev_sel = prev_reg[0];
            2'd1:    prev_sel = prev_reg[1];
            default: prev_sel = prev_reg[2];
        endcase
    end

    // Sample produced by the bit under evaluation, if any.
    always_comb
    begin
        sym_take   = 1'b0;
        new_sample = 1'b0;
        new_value  = '0;
        if (state_reg == ST_RUN)
        begin
            if (!tree_mode)
            begin
                if (hdr_last)
                begin
                    new_sample = 1'b1;
                    new_value  = sext12(hdr_shift);
                end
            end
            else if (pend_reg && child_node.leaf)
            begin
                sym_take = 1'b1;
            end
        end
        if (sym_take)
        begin
            if (mode.whole_symbols)
            begin
                new_sample = 1'b1;
                new_value  = mode.difference_mode ? sext12(sum12)
                                                  : child_node.value + SUB_2048;
            end
            else if (lowp_valid_reg)
            begin
                new_sample = 1'b1;
                new_value  = mode.difference_mode ? prev_sel + pair_val + SUB_4096
                                                  : pair_val;
            end
        end
    end

    assign stall   = new_sample && stage_valid_reg && !out_free;
    assign advance = (state_reg == ST_RUN) && (!tree_mode || pend_reg) && !stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.is_data)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance && (bit_reg == 3'd0))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!stage_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop           = 1'b0;
        rd_en             = 1'b0;
        rd_idx            = '0;
        wr_en             = 1'b0;
        push              = 1'b0;
        push_last         = 1'b0;
        bit_next          = bit_reg;
        byte_next         = byte_reg;
        pend_next         = pend_reg;
        cur_idx_next      = cur_idx_reg;
        cur_l_next        = cur_l_reg;
        cur_r_next        = cur_r_reg;
        root_l_next       = root_l_reg;
        root_r_next       = root_r_reg;
        hdr_bits_next     = hdr_bits_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        hdr_done_next     = hdr_done_reg;
        axis_next         = axis_reg;
        lowp_valid_next   = lowp_valid_reg;
        lowp_byte_next    = lowp_byte_reg;
        prev_next         = prev_reg;
        stage_valid_next  = stage_valid_reg;
        stage_sample_next = stage_sample_reg;
        stage_axis_next   = stage_axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (!cmd.is_data)
                    begin
                        wr_en = 1'b1;
                        // Keep the cached root and current node in step with the table.
                        if (cmd.idx == '0)
                        begin
                            root_l_next = cmd.node.left;
                            root_r_next = cmd.node.right;
                        end
                        if (cmd.idx == cur_idx_reg)
                        begin
                            cur_l_next = cmd.node.left;
                            cur_r_next = cmd.node.right;
                        end
                    end
                    else
                    begin
                        byte_next = cmd.data;
                        bit_next  = 3'd7;
                        if (tree_mode)
                        begin
                            rd_en     = 1'b1;
                            rd_idx    = cmd.data[BYTE_W-1] ? cur_l_reg : cur_r_reg;
                            pend_next = 1'b1;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (tree_mode && !pend_reg)
                begin
                    rd_en     = 1'b1;
                    rd_idx    = bit_val ? cur_l_reg : cur_r_reg;
                    pend_next = 1'b1;
                end
                else if (advance)
                begin
                    if (!tree_mode)
                    begin
                        if (hdr_last)
                        begin
                            hdr_bits_next = '0;
                            hdr_cnt_next  = '0;
                            if (axis_reg == AXIS_Z)
                            begin
                                hdr_done_next = 1'b1;
                            end
                        end
                        else
                        begin
                            hdr_bits_next = hdr_shift;
                            hdr_cnt_next  = hdr_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cur_idx_next = child_node.leaf ? '0 : issue_idx_reg;
                        cur_l_next   = nxt_l;
                        cur_r_next   = nxt_r;
                        if (sym_take)
                        begin
                            if (mode.whole_symbols || lowp_valid_reg)
                            begin
                                lowp_valid_next = 1'b0;
                            end
                            else
                            begin
                                lowp_valid_next = 1'b1;
                                lowp_byte_next  = child_node.value[BYTE_W-1:0];
                            end
                        end
                        // Chain the next bit's table read behind this evaluation.
                        if (bit_reg != 3'd0)
                        begin
                            rd_en  = 1'b1;
                            rd_idx = byte_reg[bit_dn] ? nxt_l : nxt_r;
                        end
                    end
                    if (bit_reg == 3'd0)
                    begin
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        bit_next = bit_dn;
                        if (!tree_mode)
                        begin
                            pend_next = 1'b0;
                        end
                    end
                    if (new_sample)
                    begin
                        prev_next[axis_reg] = new_value;
                        axis_next           = (axis_reg == AXIS_Z) ? AXIS_X : axis_reg + 1'b1;
                        push                = stage_valid_reg;
                        stage_valid_next    = 1'b1;
                        stage_sample_next   = new_value;
                        stage_axis_next     = axis_reg;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (stage_valid_reg && out_free)
                begin
                    push             = 1'b1;
                    push_last        = 1'b1;
                    stage_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_axis_next   = out_axis_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = stage_sample_reg;
            out_axis_next   = stage_axis_reg;
            out_last_next   = push_last;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pend_reg        <= 1'b0;
            cur_idx_reg     <= '0;
            hdr_bits_reg    <= '0;
            hdr_cnt_reg     <= '0;
            hdr_done_reg    <= 1'b0;
            axis_reg        <= AXIS_X;
            lowp_valid_reg  <= 1'b0;
            prev_reg[0]     <= '0;
            prev_reg[1]     <= '0;
            prev_reg[2]     <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_reg        <= pend_next;
            cur_idx_reg     <= cur_idx_next;
            hdr_bits_reg    <= hdr_bits_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            hdr_done_reg    <= hdr_done_next;
            axis_reg        <= axis_next;
            lowp_valid_reg  <= lowp_valid_next;
            prev_reg        <= prev_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg          <= bit_next;
        byte_reg         <= byte_next;
        cur_l_reg        <= cur_l_next;
        cur_r_reg        <= cur_r_next;
        root_l_reg       <= root_l_next;
        root_r_reg       <= root_r_next;
        lowp_byte_reg    <= lowp_byte_next;
        stage_sample_reg <= stage_sample_next;
        stage_axis_reg   <= stage_axis_next;
        out_sample_reg   <= out_sample_next;
        out_axis_reg     <= out_axis_next;
        out_last_reg     <= out_last_next;
        if (rd_en)
        begin
            rd_ok_reg     <= (32'(rd_idx) < TREE_NODES);
            issue_idx_reg <= rd_idx;
        end
    end

    // Tree table: one write port for loads, one registered read port for the walk.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tree_mem[cmd.idx[AW-1:0]] <= cmd.node;
        end
        if (rd_en)
        begin
            rd_data_reg <= tree_mem[rd_idx[AW-1:0]];
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.sample = out_sample_reg;
    assign result.axis   = out_axis_reg;
    assign result.last   = out_last_reg;

`ifndef SYNTHESIS
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("table read outstanding while idle");

    a_idle_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !stage_valid_reg)
        else $error("sample left in stage after byte end");

    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_done_reg |-> (hdr_cnt_reg == '0))
        else $error("header bits gathered after header end");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_axis_reg != 2'd3))
        else $error("illegal axis on result");
`endif

endmodule
`default_nettype wire

// ----- sim/huffman_delta_sample_decoder_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the Huffman delta sample decoder: loads trees, streams bytes, checks every sample.
module huffman_delta_sample_decoder_top_tb;
    import hdsd_pkg::*;

    localparam int TREE_NODES   = 16384;
    localparam int RANDOM_ITEMS = 450;
    localparam int MAX_WAIT     = 11;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [IDX_W-1:0]     ROOT        = '0;
    localparam logic [IDX_W-1:0]     TOP_NODE    = IDX_W'(TREE_NODES - 1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [VAL_W-1:0]     PAIR_BIAS   = 16'd4096;
    localparam logic [VAL_W-1:0]     WHOLE_BIAS  = 16'd2048;

    typedef struct packed {
        logic [VAL_W-1:0]  sample;
        logic [AXIS_W-1:0] axis;
        logic              last;
    } axis_sample_t;

    logic clk = 1'b0;
    logic rst_n;

    hdsd_in_if  item_ch ();
    hdsd_out_if result_ch ();
    hdsd_cfg_if cfg_ch ();

    huffman_delta_sample_decoder_top #(
        .TREE_NODES(TREE_NODES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch),
        .cfg(cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder state as predicted
    node_t             tree_mem [TREE_NODES];
    cfg_t              regs;
    logic [IDX_W-1:0]  walk_node;
    logic [HDR_W-1:0]  hdr_bits;
    int                hdr_cnt;
    logic [AXIS_W-1:0] next_axis;
    logic              low_held;
    logic [7:0]        low_byte;
    logic [VAL_W-1:0]  last_value [3];
    logic              hdr_done;
    axis_sample_t      pending_samples [$];

    // Stimulus bookkeeping
    bit                is_loaded [TREE_NODES];
    logic [IDX_W-1:0]  loaded_nodes [$];
    bit                tree_used [int];
    bit                gaps_on;
    bit                stalls_on;
    int                mismatches = 0;
    int                quiet_cycles = 0;

    function automatic logic [VAL_W-1:0] widen12(input logic [HDR_W-1:0] v);
        return {{(VAL_W - HDR_W){v[HDR_W-1]}}, v};
    endfunction

    function automatic void reset_prediction();
        regs.difference_mode = 1'b1;
        regs.whole_symbols   = 1'b0;
        walk_node = ROOT;
        hdr_bits  = '0;
        hdr_cnt   = 0;
        next_axis = AXIS_X;
        low_held  = 1'b0;
        low_byte  = '0;
        hdr_done  = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            last_value[a] = '0;
        end
    endfunction

    function automatic void push_sample(input logic [VAL_W-1:0] value);
        axis_sample_t s;
        s.sample = value;
        s.axis   = next_axis;
        s.last   = 1'b0;
        pending_samples.push_back(s);
        next_axis = (next_axis == AXIS_Z) ? AXIS_X : next_axis + 2'd1;
    endfunction

    function automatic void rebuild_sample(input logic [VAL_W-1:0] sym);
        logic [VAL_W-1:0] t;
        logic [VAL_W-1:0] p;
        p = last_value[next_axis];
        if (regs.whole_symbols)
        begin
            // a held low byte is dropped by any whole symbol
            low_held = 1'b0;
            t = sym;
        end
        else if (!low_held)
        begin
            low_held = 1'b1;
            low_byte = sym[7:0];
            return;
        end
        else
        begin
            t = {sym[7:0], low_byte};
            low_held = 1'b0;
        end
        if (regs.difference_mode)
        begin
            // the 4096 offset vanishes modulo 12 bits
            if (regs.whole_symbols)
                p = widen12(p[HDR_W-1:0] + t[HDR_W-1:0]);
            else
                p = p + t - PAIR_BIAS;
        end
        else
        begin
            if (regs.whole_symbols)
                p = t - WHOLE_BIAS;
            else
                p = t;
        end
        last_value[next_axis] = p;
        push_sample(p);
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] data);
        int               start_n;
        node_t            here;
        node_t            hop;
        logic [IDX_W-1:0] child;
        logic             b;
        start_n = pending_samples.size();
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            b = data[i];
            if (regs.difference_mode && !hdr_done)
            begin
                hdr_bits = {hdr_bits[HDR_W-2:0], b};
                hdr_cnt++;
                if (hdr_cnt == HDR_W)
                begin
                    last_value[next_axis] = widen12(hdr_bits);
                    if (next_axis == AXIS_Z)
                        hdr_done = 1'b1;
                    push_sample(widen12(hdr_bits));
                    hdr_bits = '0;
                    hdr_cnt  = 0;
                end
            end
            else
            begin
                // leaf flag of the current node is never consulted
                here  = tree_mem[walk_node];
                child = b ? here.left : here.right;
                hop   = tree_mem[child];
                if (hop.leaf)
                begin
                    walk_node = ROOT;
                    rebuild_sample(hop.value);
                end
                else
                begin
                    walk_node = child;
                end
            end
        end
        if (pending_samples.size() > start_n)
            pending_samples[pending_samples.size() - 1].last = 1'b1;
    endfunction

    function automatic void store_node(input logic [IDX_W-1:0] idx, input node_t n);
        if (int'(idx) < TREE_NODES)
            tree_mem[idx] = n;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] index, input logic data);
        case (index)
            REG_DIFFERENCE_MODE: regs.difference_mode = data;
            REG_WHOLE_SYMBOLS:   regs.whole_symbols = data;
            default: ;
        endcase
    endfunction

    function automatic void note_loaded(input logic [IDX_W-1:0] idx);
        if (!is_loaded[idx])
        begin
            is_loaded[idx] = 1'b1;
            loaded_nodes.push_back(idx);
        end
    endfunction

    function automatic logic [IDX_W-1:0] pick_loaded();
        return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
    endfunction

    function automatic logic [IDX_W-1:0] pick_free_index();
        logic [IDX_W-1:0] idx;
        do
            idx = IDX_W'($urandom_range(1, TREE_NODES - 1));
        while (tree_used.exists(int'(idx)));
        tree_used[int'(idx)] = 1'b1;
        return idx;
    endfunction

    task automatic send_item(input cmd_t c);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.operation    <= c.is_data;
        item_ch.node_index   <= c.idx;
        item_ch.node_is_leaf <= c.node.leaf;
        item_ch.node_left    <= c.node.left;
        item_ch.node_right   <= c.node.right;
        item_ch.node_value   <= c.node.value;
        item_ch.data_byte    <= c.data;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (c.is_data == OP_DATA)
            decode_byte(c.data);
        else
            store_node(c.idx, c.node);
    endtask

    task automatic send_node(input logic [IDX_W-1:0] idx, input logic leaf,
                             input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right,
                             input logic [VAL_W-1:0] value);
        cmd_t c;
        note_loaded(idx);
        c.is_data    = OP_LOAD;
        c.idx        = idx;
        c.node.leaf  = leaf;
        c.node.left  = left;
        c.node.right = right;
        c.node.value = value;
        c.data       = BYTE_W'($urandom);
        send_item(c);
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] data);
        cmd_t c;
        // unused node fields carry noise
        c.is_data    = OP_DATA;
        c.idx        = IDX_W'($urandom);
        c.node.leaf  = 1'($urandom);
        c.node.left  = IDX_W'($urandom);
        c.node.right = IDX_W'($urandom);
        c.node.value = VAL_W'($urandom);
        c.data       = data;
        send_item(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg(index, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold the item side until every sample is out and the back end has gone quiet.
    task automatic drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Loads a well-formed tree with the given number of leaves; root lands at node 0.
    task automatic build_tree(input int leaves, inout int count);
        logic [IDX_W-1:0] frontier [$];
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        int               k;
        tree_used.delete();
        for (int i = 0; i < leaves; i++)
        begin
            idx = pick_free_index();
            note_loaded(idx);
            send_node(idx, 1'b1, pick_loaded(), pick_loaded(), VAL_W'($urandom));
            frontier.push_back(idx);
            count++;
        end
        while (frontier.size() > 2)
        begin
            k = $urandom_range(0, frontier.size() - 1);
            a = frontier[k];
            frontier.delete(k);
            k = $urandom_range(0, frontier.size() - 1);
            b = frontier[k];
            frontier.delete(k);
            idx = pick_free_index();
            send_node(idx, 1'b0, a, b, VAL_W'($urandom));
            frontier.push_back(idx);
            count++;
        end
        send_node(ROOT, 1'($urandom), frontier[0], frontier[frontier.size() - 1],
                  VAL_W'($urandom));
        count++;
    endtask

    task automatic test_header_and_pairs();
        // node 2 is an inner node so that a symbol can take one or two bits
        send_node(TOP_NODE, 1'b1, ROOT, TOP_NODE, 16'h7FFF);
        send_node(14'd1, 1'b1, TOP_NODE, ROOT, 16'h8000);
        send_node(14'd2, 1'b0, 14'd1, TOP_NODE, 16'h0000);
        send_node(ROOT, 1'b0, TOP_NODE, 14'd2, 16'h0000);
        // header x = 0x800, y = 0x7FF, z = 0xFFF, then four walk bits in the same byte
        send_data(8'h80);
        send_data(8'h07);
        send_data(8'hFF);
        send_data(8'hFF);
        send_data(8'hFA);
        // odd symbol count leaves a low byte held
        send_data(8'h3F);
    endtask

    task automatic test_whole_symbols();
        drain_results();
        write_reg(REG_WHOLE_SYMBOLS, 1'b1);
        send_data(8'hFF);
        send_data(8'h00);
    endtask

    task automatic test_absolute_modes();
        drain_results();
        write_reg(REG_DIFFERENCE_MODE, 1'b0);
        send_data(8'h55);
        drain_results();
        write_reg(REG_WHOLE_SYMBOLS, 1'b0);
        send_data(8'hA5);
        send_data(8'h00);
        send_data(8'hFF);
    endtask

    task automatic test_spare_reg_index();
        drain_results();
        write_reg(REG_SPARE_2, 1'b1);
        write_reg(REG_SPARE_3, 1'b0);
        send_data(8'hC3);
    endtask

    task automatic test_root_leaf();
        // root flagged as leaf, and reached again as a child through node 2
        send_node(ROOT, 1'b1, TOP_NODE, 14'd2, 16'h1234);
        send_node(14'd2, 1'b0, ROOT, TOP_NODE, 16'h0000);
        send_data(8'h4B);
        send_data(8'h00);
    endtask

    task automatic test_random_streams();
        int               sent;
        int               bytes;
        logic [IDX_W-1:0] idx;
        sent = 0;
        for (int round = 0; sent < RANDOM_ITEMS; round++)
        begin
            drain_results();
            write_reg(REG_DIFFERENCE_MODE, 1'($urandom_range(0, 1)));
            write_reg(REG_WHOLE_SYMBOLS, 1'($urandom_range(0, 1)));
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (round == 0 || $urandom_range(0, 1) == 1)
                build_tree($urandom_range(1, 8), sent);
            bytes = $urandom_range(8, 30);
            repeat (bytes)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // overwrite a node mid-stream; children stay on loaded nodes
                    idx = IDX_W'($urandom_range(0, TREE_NODES - 1));
                    note_loaded(idx);
                    send_node(idx, 1'($urandom), pick_loaded(), pick_loaded(),
                              VAL_W'($urandom));
                end
                else
                begin
                    send_data(BYTE_W'($urandom));
                end
                sent++;
            end
        end
    endtask

    initial
    begin : result_sink
        axis_sample_t want;
        int           stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            @(negedge clk);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            if (pending_samples.size() == 0)
            begin
                $error("unexpected sample %0d on axis %0d", $signed(result_ch.sample),
                       result_ch.axis);
                mismatches++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (result_ch.sample !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", $signed(want.sample),
                           $signed(result_ch.sample));
                    mismatches++;
                end
                if (result_ch.axis !== want.axis)
                begin
                    $error("axis: expected %0d, got %0d", want.axis, result_ch.axis);
                    mismatches++;
                end
                if (result_ch.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, result_ch.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** huffman_delta_sample_decoder_top: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.operation    = OP_LOAD;
        item_ch.node_index   = '0;
        item_ch.node_is_leaf = 1'b0;
        item_ch.node_left    = '0;
        item_ch.node_right   = '0;
        item_ch.node_value   = '0;
        item_ch.data_byte    = '0;
        result_ch.ready      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_DIFFERENCE_MODE;
        cfg_ch.data          = 1'b0;
        gaps_on              = 1'b1;
        stalls_on            = 1'b1;
        reset_prediction();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_header_and_pairs();
        test_whole_symbols();
        test_absolute_modes();
        test_spare_reg_index();
        test_root_leaf();
        test_random_streams();

        drain_results();
        if (mismatches == 0)
            $display("** huffman_delta_sample_decoder_top: PASSED **");
        else
            $display("** huffman_delta_sample_decoder_top: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/hdsd_pkg.sv
src/hdsd_if.sv
src/hdsd_front.sv
src/hdsd_fifo.sv
src/hdsd_back.sv
src/huffman_delta_sample_decoder_top.sv
sim/huffman_delta_sample_decoder_top_tb.sv
